/* hw/rtl/odtt_pkg.sv */
// ----------------------------------------------------------------------------
// Order tick table package
// Shared constants, operation codes and record types of the order tick table.
// ----------------------------------------------------------------------------
package odtt_pkg;

    // Number of table slots; a power of two, so the slot is the low id bits.
    localparam int unsigned SLOTS  = 1024;
    localparam int unsigned SLOT_W = $clog2(SLOTS);

    localparam int unsigned ID_W    = 64;
    localparam int unsigned TICKS_W = 64;
    localparam int unsigned COUNT_W = 32;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_STORE  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_ERASE  = 2'd2
    } kind_t;

    // One table entry as it sits in the memory.
    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    tag;
        logic [TICKS_W-1:0] ticks;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // One result item.
    typedef struct packed {
        logic               hit;
        logic [TICKS_W-1:0] stored_ticks;
        logic [COUNT_W-1:0] collision_total;
    } result_t;

endpackage

/* hw/rtl/odtt_ram.sv */
// ----------------------------------------------------------------------------
// Order tick table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module odtt_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/odtt_update.sv */
// ----------------------------------------------------------------------------
// Order tick table update
// Works out the new entry, the result and the next collision count of one
// operation from the entry read out of the table.
// ----------------------------------------------------------------------------
module odtt_update (
    input  logic [1:0]                   kind,
    input  logic [odtt_pkg::ID_W-1:0]    order_id,
    input  logic [odtt_pkg::TICKS_W-1:0] tick_value,
    input  odtt_pkg::entry_t             entry_rd,
    input  logic [odtt_pkg::COUNT_W-1:0] count_cur,
    output odtt_pkg::entry_t             entry_wr,
    output odtt_pkg::result_t            result,
    output logic [odtt_pkg::COUNT_W-1:0] count_new
);

    logic match;
    logic evict;

    assign match = entry_rd.valid && (entry_rd.tag == order_id);
    assign evict = entry_rd.valid && (entry_rd.tag != order_id);

    always_comb
    begin
        entry_wr               = entry_rd;
        count_new              = count_cur;
        result.hit             = 1'b0;
        result.stored_ticks    = '0;
        unique case (odtt_pkg::kind_t'(kind))
            odtt_pkg::KIND_STORE:
            begin
                if (evict && (count_cur != {odtt_pkg::COUNT_W{1'b1}}))
                begin
                    count_new = count_cur + 1'b1;
                end
                entry_wr.valid = 1'b1;
                entry_wr.tag   = order_id;
                entry_wr.ticks = tick_value;
            end
            odtt_pkg::KIND_LOOKUP:
            begin
                if (match)
                begin
                    result.hit          = 1'b1;
                    result.stored_ticks = entry_rd.ticks;
                end
            end
            odtt_pkg::KIND_ERASE:
            begin
                if (match)
                begin
                    entry_wr.valid = 1'b0;
                end
            end
            default:
            begin
                // The unused code leaves the table alone.
                entry_wr = entry_rd;
            end
        endcase
        result.collision_total = count_new;
    end

endmodule

/* hw/rtl/odtt_out_fifo.sv */
// ----------------------------------------------------------------------------
// Order tick table output buffer
// Two-entry result queue that decouples the table pipeline from the sink.
// ----------------------------------------------------------------------------
module odtt_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  odtt_pkg::result_t push_data,
    input  logic              pop,
    output odtt_pkg::result_t head,
    output logic              not_empty,
    output logic [1:0]        count
);

    odtt_pkg::result_t slots_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = slots_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign count     = count_reg;

endmodule

/* hw/rtl/direct_mapped_order_tick_table_top.sv */
// ----------------------------------------------------------------------------
// Direct-mapped order tick table
// Maps a 64-bit order id to a 64-bit tick stamp with store, lookup and erase.
// ----------------------------------------------------------------------------
// The table holds 1024 slots, each with a valid bit, the full order id as a
// tag and a tick stamp, all in one synchronous RAM word; the slot is the low
// ten bits of the order id. After reset the block runs a clearing pass that
// writes one slot per cycle, so s_tready stays low until all slots are clear.
// From then on it takes one transfer per cycle as long as the sink keeps
// m_tready high: an item reads its slot at the accepting edge, the update
// logic works on the read data in the next cycle and writes the slot back
// while the result enters a two-entry output queue. The result is registered
// in that queue before it shows up on m_tvalid. The single RAM read port and
// write port set the transfer rate; a stalled sink holds s_tready low once
// the queue and the update stage together hold two results. Back-to-back
// items on the same slot see each other's writes through a forwarding
// register. Every item, including the unused kind code, gives exactly one
// result.
// ----------------------------------------------------------------------------
module direct_mapped_order_tick_table_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // order_id [63:0], tick_value [127:64]
    input  logic [1:0]   s_tuser,   // kind [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // hit [0], stored_ticks [64:1],
                                    // collision_total [96:65], zero fill above
);

    logic s_accept;
    logic m_accept;

    // Clearing pass state.
    logic                        clearing_reg;
    logic                        clearing_next;
    logic [odtt_pkg::SLOT_W-1:0] clear_idx_reg;
    logic [odtt_pkg::SLOT_W-1:0] clear_idx_next;

    // Update stage: the item whose slot data arrives from the RAM this cycle.
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [1:0]                   s1_kind_reg;
    logic [odtt_pkg::ID_W-1:0]    s1_id_reg;
    logic [odtt_pkg::TICKS_W-1:0] s1_ticks_reg;

    // Last write-back, for a read that was issued at the same edge.
    logic                        fwd_valid_reg;
    logic                        fwd_valid_next;
    logic [odtt_pkg::SLOT_W-1:0] fwd_slot_reg;
    odtt_pkg::entry_t            fwd_data_reg;

    logic [odtt_pkg::COUNT_W-1:0] coll_reg;
    logic [odtt_pkg::COUNT_W-1:0] coll_next;
    logic [odtt_pkg::COUNT_W-1:0] coll_next_stage;

    logic [odtt_pkg::SLOT_W-1:0]  s1_slot;
    logic [odtt_pkg::ENTRY_W-1:0] ram_rdata;
    logic                         ram_we;
    logic [odtt_pkg::SLOT_W-1:0]  ram_waddr;
    logic [odtt_pkg::ENTRY_W-1:0] ram_wdata;
    odtt_pkg::entry_t             entry_rd;
    odtt_pkg::entry_t             entry_wr;
    odtt_pkg::result_t            result;
    odtt_pkg::result_t            fifo_head;
    logic                         fifo_not_empty;
    logic [1:0]                   fifo_count;
    logic [1:0]                   occupancy;
    logic [1:0]                   occupancy_left;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // An item may enter only if its result is sure of a queue place, counting
    // the item already in the update stage and a result leaving this cycle.
    assign occupancy      = fifo_count + {1'b0, s1_valid_reg};
    assign occupancy_left = occupancy - {1'b0, m_accept};
    assign s_tready       = !clearing_reg && (occupancy_left < 2'd2);

    // Clearing pass.
    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_idx_next = clear_idx_reg;
        if (clearing_reg)
        begin
            clear_idx_next = clear_idx_reg + 1'b1;
            if (clear_idx_reg == odtt_pkg::SLOT_W'(odtt_pkg::SLOTS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    assign s1_valid_next  = s_accept;
    assign fwd_valid_next = s1_valid_reg;
    assign s1_slot        = s1_id_reg[odtt_pkg::SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            coll_reg      <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clear_idx_reg <= clear_idx_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            coll_reg      <= coll_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_kind_reg  <= s_tuser;
            s1_id_reg    <= s_tdata[63:0];
            s1_ticks_reg <= s_tdata[127:64];
        end
        if (s1_valid_reg)
        begin
            fwd_slot_reg <= s1_slot;
            fwd_data_reg <= entry_wr;
        end
    end

    // The write-back of the previous item landed at the same edge that this
    // item's read was issued, so the RAM returned the older contents.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_slot_reg == s1_slot))
        begin
            entry_rd = fwd_data_reg;
        end
        else
        begin
            entry_rd = odtt_pkg::entry_t'(ram_rdata);
        end
    end

    odtt_update u_update (
        .kind       (s1_kind_reg),
        .order_id   (s1_id_reg),
        .tick_value (s1_ticks_reg),
        .entry_rd   (entry_rd),
        .count_cur  (coll_reg),
        .entry_wr   (entry_wr),
        .result     (result),
        .count_new  (coll_next_stage)
    );

    assign coll_next = s1_valid_reg ? coll_next_stage : coll_reg;

    // The clearing pass owns the write port until it ends; no item is in
    // flight during that time.
    assign ram_we    = clearing_reg || s1_valid_reg;
    assign ram_waddr = clearing_reg ? clear_idx_reg : s1_slot;
    assign ram_wdata = clearing_reg ? '0 : odtt_pkg::ENTRY_W'(entry_wr);

    odtt_ram #(
        .WIDTH (odtt_pkg::ENTRY_W),
        .DEPTH (odtt_pkg::SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (s_tdata[odtt_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    odtt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (result),
        .pop       (m_accept),
        .head      (fifo_head),
        .not_empty (fifo_not_empty),
        .count     (fifo_count)
    );

    assign m_tvalid = fifo_not_empty;
    assign m_tdata  = {7'd0, fifo_head.collision_total, fifo_head.stored_ticks,
                       fifo_head.hit};

    // The queue always has room for the result leaving the update stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((fifo_count < 2'd2) || m_accept))
        else $error("result queue overflow");

    // No item is in flight while the clearing pass owns the RAM.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !s_tready))
        else $error("item in flight during clearing pass");

    // The collision count holds its value in a cycle without an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |=> (coll_reg == $past(coll_reg)))
        else $error("collision count changed without an item");

endmodule

/* tb/tb_direct_mapped_order_tick_table_top.sv */
// ----------------------------------------------------------------------------
// Order tick table testbench
// Drives store, lookup and erase transfers into the direct-mapped order tick
// table and checks every result against a table model kept in the bench.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the valid bits, tags, tick stamps and the
// collision count. When an input transfer is accepted, the model applies the
// operation and queues the result it predicts. The result monitor compares
// each output transfer, field by field, with the oldest queued result.
//
// The test tasks run in this order:
//   - a directed pass over the extreme ids and tick stamps, every operation,
//     tag mismatches, erase of an empty slot, the unused kind code and
//     back-to-back hits on one slot;
//   - a long random mix that crowds a few slots, so that collisions, hits
//     and misses are frequent;
//   - a pause in which the sender waits until every result has returned;
//   - a closing burst with no idling on either side.
// Lookups, erases and the unused kind only ever address slots that were
// stored at least once, because the tag and stamp of a slot are undefined
// until the first store. The collision count cannot reach its saturation
// value within a run of this length.
// ----------------------------------------------------------------------------
module tb_direct_mapped_order_tick_table_top;

    // The one kind code that the package leaves without an operation.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 10;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = odtt_pkg::KIND_STORE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    // Bench copy of the table.
    bit                           slot_valid   [odtt_pkg::SLOTS];
    logic [odtt_pkg::ID_W-1:0]    slot_tag     [odtt_pkg::SLOTS];
    logic [odtt_pkg::TICKS_W-1:0] slot_ticks   [odtt_pkg::SLOTS];
    bit                           slot_written [odtt_pkg::SLOTS];
    logic [odtt_pkg::COUNT_W-1:0] collisions = '0;
    int unsigned                  written_slots[$];

    // Results predicted for accepted transfers, oldest first.
    odtt_pkg::result_t pending_results[$];

    // Upper id bits shared by many random ids, so that tags match often.
    logic [odtt_pkg::ID_W-1:0] tag_pool[4];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned sink_stall     = 0;
    bit          idle_on        = 1'b0;

    always #5 clk = ~clk;

    direct_mapped_order_tick_table_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Applies one operation to the bench table and returns the result that
    // the block must produce for it.
    function automatic odtt_pkg::result_t table_apply(
        input logic [1:0]                   kind,
        input logic [odtt_pkg::ID_W-1:0]    id,
        input logic [odtt_pkg::TICKS_W-1:0] tick);
        int unsigned       slot;
        bit                match;
        odtt_pkg::result_t res;
        slot  = 32'(id[odtt_pkg::SLOT_W-1:0]);
        match = slot_valid[slot] && (slot_tag[slot] == id);
        res   = '0;
        if (kind == odtt_pkg::KIND_STORE)
        begin
            // Evicting a live entry of another order is a collision.
            if (slot_valid[slot] && slot_tag[slot] != id && collisions != '1)
                collisions = collisions + 1'b1;
            slot_valid[slot] = 1'b1;
            slot_tag[slot]   = id;
            slot_ticks[slot] = tick;
            if (!slot_written[slot])
            begin
                slot_written[slot] = 1'b1;
                written_slots.push_back(slot);
            end
        end
        else if (kind == odtt_pkg::KIND_LOOKUP)
        begin
            if (match)
            begin
                res.hit          = 1'b1;
                res.stored_ticks = slot_ticks[slot];
            end
        end
        else if (kind == odtt_pkg::KIND_ERASE)
        begin
            if (match)
                slot_valid[slot] = 1'b0;
        end
        // The unused kind leaves the table alone and only reports the count.
        res.collision_total = collisions;
        return res;
    endfunction

    // Offers one transfer, optionally after a short gap, and holds it until
    // the block accepts it. The prediction is made at the accepting edge.
    task automatic send_op(input logic [1:0] kind,
                           input logic [odtt_pkg::ID_W-1:0] id,
                           input logic [odtt_pkg::TICKS_W-1:0] tick);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tick, id};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(table_apply(kind, id, tick));
    endtask

    // An id whose upper bits come from the shared pool, in the given slot.
    function automatic logic [odtt_pkg::ID_W-1:0] pooled_id(input int unsigned slot);
        logic [odtt_pkg::ID_W-1:0] upper;
        upper = tag_pool[$urandom_range(0, 3)];
        return {upper[odtt_pkg::ID_W-1:odtt_pkg::SLOT_W], odtt_pkg::SLOT_W'(slot)};
    endfunction

    // One random operation. Stores mostly land in the first sixteen slots to
    // force evictions; the other kinds only touch slots stored before.
    task automatic send_random_op();
        int unsigned               pick;
        int unsigned               slot;
        logic [1:0]                kind;
        logic [odtt_pkg::ID_W-1:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 45 || written_slots.size() == 0)
        begin
            if (pick % 10 == 0)
                id = {$urandom, $urandom};
            else if (pick % 10 == 1)
                id = pooled_id($urandom_range(0, odtt_pkg::SLOTS - 1));
            else
                id = pooled_id($urandom_range(0, 15));
            send_op(odtt_pkg::KIND_STORE, id, {$urandom, $urandom});
        end
        else
        begin
            slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
            if ($urandom_range(0, 9) < 6)
                id = slot_tag[slot];
            else
                id = pooled_id(slot);
            if (pick < 75)
                kind = odtt_pkg::KIND_LOOKUP;
            else if (pick < 95)
                kind = odtt_pkg::KIND_ERASE;
            else
                kind = KIND_UNUSED;
            send_op(kind, id, {$urandom, $urandom});
        end
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Extreme ids and stamps, every operation and the corner cases of the
    // slot logic, sent back to back so forwarding is exercised too.
    task automatic test_directed();
        logic [odtt_pkg::ID_W-1:0] id_zero;
        logic [odtt_pkg::ID_W-1:0] id_alias;
        logic [odtt_pkg::ID_W-1:0] id_top;
        id_zero  = '0;
        id_alias = {{(odtt_pkg::ID_W - odtt_pkg::SLOT_W){1'b1}},
                    {odtt_pkg::SLOT_W{1'b0}}};
        id_top   = '1;
        idle_on  = 1'b0;
        send_op(odtt_pkg::KIND_STORE,  id_zero,  '1);
        send_op(odtt_pkg::KIND_LOOKUP, id_zero,  '0);
        // Same slot, different tag: a miss, then a store that evicts.
        send_op(odtt_pkg::KIND_LOOKUP, id_alias, '1);
        send_op(odtt_pkg::KIND_STORE,  id_alias, '0);
        send_op(odtt_pkg::KIND_LOOKUP, id_alias, '1);
        send_op(odtt_pkg::KIND_LOOKUP, id_zero,  '0);
        // An erase with the wrong tag must leave the entry in place.
        send_op(odtt_pkg::KIND_ERASE,  id_zero,  '1);
        send_op(odtt_pkg::KIND_LOOKUP, id_alias, '0);
        send_op(odtt_pkg::KIND_ERASE,  id_alias, '0);
        send_op(odtt_pkg::KIND_LOOKUP, id_alias, '1);
        // Storing into an empty slot is never a collision, and neither is
        // overwriting the same order.
        send_op(odtt_pkg::KIND_STORE,  id_zero,  64'h5555_5555_5555_5555);
        send_op(odtt_pkg::KIND_STORE,  id_zero,  64'hAAAA_AAAA_AAAA_AAAA);
        send_op(odtt_pkg::KIND_LOOKUP, id_zero,  '0);
        send_op(odtt_pkg::KIND_STORE,  id_top,   '1);
        send_op(KIND_UNUSED,           id_top,   '1);
        send_op(odtt_pkg::KIND_LOOKUP, id_top,   '0);
        send_op(odtt_pkg::KIND_ERASE,  id_top,   '0);
        // Erasing a slot that is already empty changes nothing.
        send_op(odtt_pkg::KIND_ERASE,  id_top,   '1);
        send_op(odtt_pkg::KIND_LOOKUP, id_top,   '1);
        send_op(odtt_pkg::KIND_STORE,  id_top,   64'h0123_4567_89AB_CDEF);
        send_op(odtt_pkg::KIND_LOOKUP, id_top,   '0);
        send_op(KIND_UNUSED,           id_zero,  '0);
    endtask

    task automatic test_random_mix();
        idle_on = 1'b1;
        repeat (330)
            send_random_op();
    endtask

    // The sender holds off until the output side has returned everything.
    task automatic test_pause_until_drained();
        idle_on = 1'b1;
        repeat (20)
            send_random_op();
        s_tvalid <= 1'b0;
        wait_results_drained();
        @(posedge clk);
        repeat (20)
            send_random_op();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (60)
            send_random_op();
    endtask

    // Reports one bad result in detail while the report budget lasts.
    task automatic log_mismatch(input string what, input odtt_pkg::result_t want,
                                input odtt_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch (%s) at cycle %0d: expected hit=%0b ticks=%h total=%0d,",
                      " got hit=%0b ticks=%h total=%0d"},
                     what, cycle_count, want.hit, want.stored_ticks,
                     want.collision_total, got.hit, got.stored_ticks,
                     got.collision_total);
    endtask

    // Result monitor and output-side stall generator.
    always @(posedge clk)
    begin
        odtt_pkg::result_t got;
        odtt_pkg::result_t want;
        got.hit             = m_tdata[0];
        got.stored_ticks    = m_tdata[64:1];
        got.collision_total = m_tdata[96:65];
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                log_mismatch("no result expected", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.hit != want.hit || got.stored_ticks != want.stored_ticks
                    || got.collision_total != want.collision_total)
                    log_mismatch("field", want, got);
            end
        end
        if (sink_stall != 0)
        begin
            sink_stall <= sink_stall - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sink_stall <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("direct_mapped_order_tick_table_top verification failed");
            $finish;
        end
    end

    initial
    begin
        foreach (tag_pool[k])
            tag_pool[k] = {$urandom, $urandom};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The clearing pass after reset is absorbed by the wait for s_tready.
        test_directed();
        test_random_mix();
        test_pause_until_drained();
        test_back_to_back();

        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("direct_mapped_order_tick_table_top verification clean");
        else
            $display("direct_mapped_order_tick_table_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/odtt_pkg.sv
hw/rtl/odtt_ram.sv
hw/rtl/odtt_update.sv
hw/rtl/odtt_out_fifo.sv
hw/rtl/direct_mapped_order_tick_table_top.sv
tb/tb_direct_mapped_order_tick_table_top.sv
